>>> design/flm_pkg.sv
// ----------------------------------------------------------------------------
// flm_pkg
// Types and constants shared by the lock manager controller, datapath and top.
// ----------------------------------------------------------------------------
package flm_pkg;

  localparam int unsigned DEF_NUM_RESOURCES = 2;
  localparam int unsigned DEF_QUEUE_DEPTH   = 8;

  localparam int unsigned REQUESTER_W = 4;
  localparam int unsigned STATUS_W    = 3;

  typedef enum logic {
    CMD_UNLOCK = 1'b0,
    CMD_LOCK   = 1'b1
  } command_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_HANDED  = 3'd2,
    ST_FREED   = 3'd3,
    ST_DROPPED = 3'd4
  } status_e;

  typedef struct packed {
    logic                   command;
    logic [REQUESTER_W-1:0] requester;
    logic                   resource;
  } lock_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   grant_valid;
    logic [REQUESTER_W-1:0] grant_to;
    logic                   grant_resource;
  } lock_rsp_t;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_EXEC = 2'd1,
    CS_LOAD = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> design/fifo_lock_manager_top.sv
// ----------------------------------------------------------------------------
// fifo_lock_manager_top
// Lock manager with a FIFO wait queue per resource.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one lock or unlock
//   request per transfer, naming a requester and a resource.
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//   result per request, in request order: status plus the grant, if any.
//   Each request passes through capture, execute (state update and one
//   access to the waiter store) and load of the result register. The waiter
//   store's registered read port sets the execute/load split. A new request
//   is taken only after the last one is loaded into the result register.
//   The result register parts the channels: a new request is taken while a
//   finished result waits. When the receiver stalls, the next result waits
//   in the load step and input is stalled until the register frees.
//   Reset marks all resources free with empty queues; no clearing pass.
// ----------------------------------------------------------------------------
module fifo_lock_manager_top #(
  parameter int unsigned NUM_RESOURCES = flm_pkg::DEF_NUM_RESOURCES,
  parameter int unsigned QUEUE_DEPTH   = flm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  flm_pkg::lock_req_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output flm_pkg::lock_rsp_t out_data_o
);
  import flm_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  flm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  flm_dpath #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> design/flm_ctrl.sv
// ----------------------------------------------------------------------------
// flm_ctrl
// Sequencer: capture one request, execute it, load its result for transfer.
// ----------------------------------------------------------------------------
module flm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  flm_pkg::ctrl_sts_t sts_i,
  output flm_pkg::ctrl_cmd_t cmd_o
);
  import flm_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          state_d = CS_EXEC;
        end
      end
      CS_EXEC: begin
        state_d = CS_LOAD;
      end
      CS_LOAD: begin
        if (sts_i.out_free) begin
          state_d = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      CS_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      CS_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      CS_LOAD: begin
        cmd_o.load = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

>>> design/flm_dpath.sv
// ----------------------------------------------------------------------------
// flm_dpath
// Lock state, per-resource wait rings, waiter store and result register.
// ----------------------------------------------------------------------------
module flm_dpath #(
  parameter int unsigned NUM_RESOURCES = flm_pkg::DEF_NUM_RESOURCES,
  parameter int unsigned QUEUE_DEPTH   = flm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  flm_pkg::lock_req_t in_data_i,
  output flm_pkg::lock_rsp_t out_data_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  flm_pkg::ctrl_cmd_t cmd_i,
  output flm_pkg::ctrl_sts_t sts_o
);
  import flm_pkg::*;

  localparam int unsigned RIDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int unsigned QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW     = CW + 1;
  localparam int unsigned AW     = RIDX_W + QW;
  localparam int unsigned MEM_DEPTH = 1 << AW;
  localparam logic [SW-1:0] QD_S = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] QD_C = CW'(QUEUE_DEPTH);

  logic                   cmd_q;
  logic [REQUESTER_W-1:0] who_q;
  logic [RIDX_W-1:0]      res_q;

  logic                   held_q  [NUM_RESOURCES];
  logic [QW-1:0]          head_q  [NUM_RESOURCES];
  logic [CW-1:0]          count_q [NUM_RESOURCES];

  logic [REQUESTER_W-1:0] wait_mem [MEM_DEPTH];
  logic [REQUESTER_W-1:0] rdata_q;

  logic [STATUS_W-1:0]    pend_status_q, pend_status_d;
  logic                   pend_valid_q, pend_valid_d;
  logic                   pend_handed_q;

  logic                   out_valid_q;
  lock_rsp_t              out_q, out_d;

  logic                   held_cur;
  logic [QW-1:0]          head_cur;
  logic [CW-1:0]          count_cur;
  logic [SW-1:0]          slot_sum;
  logic [QW-1:0]          tail_slot;
  logic [SW-1:0]          head_inc;
  logic [QW-1:0]          head_nxt;
  logic                   do_grant, do_queue, do_hand, do_free;

  assign held_cur  = held_q[res_q];
  assign head_cur  = head_q[res_q];
  assign count_cur = count_q[res_q];

  always_comb begin
    slot_sum = SW'(head_cur) + SW'(count_cur);
    if (slot_sum >= QD_S) begin
      slot_sum = slot_sum - QD_S;
    end
    tail_slot = slot_sum[QW-1:0];
    head_inc  = SW'(head_cur) + SW'(1);
    head_nxt  = (head_inc == QD_S) ? '0 : head_inc[QW-1:0];
  end

  always_comb begin
    do_grant      = 1'b0;
    do_queue      = 1'b0;
    do_hand       = 1'b0;
    do_free       = 1'b0;
    pend_status_d = ST_DROPPED;
    pend_valid_d  = 1'b0;
    if (cmd_q == CMD_LOCK) begin
      if (!held_cur) begin
        do_grant      = 1'b1;
        pend_status_d = ST_GRANTED;
        pend_valid_d  = 1'b1;
      end else if (count_cur != QD_C) begin
        do_queue      = 1'b1;
        pend_status_d = ST_QUEUED;
      end
    end else begin
      if (count_cur != '0) begin
        do_hand       = 1'b1;
        pend_status_d = ST_HANDED;
        pend_valid_d  = 1'b1;
      end else begin
        do_free       = 1'b1;
        pend_status_d = ST_FREED;
      end
    end
  end

  // capture request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= in_data_i.command;
      who_q <= in_data_i.requester;
      res_q <= (NUM_RESOURCES > 1) ? RIDX_W'(in_data_i.resource) : '0;
    end
  end

  // lock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned r = 0; r < NUM_RESOURCES; r++) begin
        held_q[r]  <= 1'b0;
        head_q[r]  <= '0;
        count_q[r] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (do_grant || do_hand) begin
        held_q[res_q] <= 1'b1;
      end
      if (do_free) begin
        held_q[res_q] <= 1'b0;
      end
      if (do_queue) begin
        count_q[res_q] <= count_cur + CW'(1);
      end
      if (do_hand) begin
        count_q[res_q] <= count_cur - CW'(1);
        head_q[res_q]  <= head_nxt;
      end
    end
  end

  // waiter store
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_queue) begin
      wait_mem[{res_q, tail_slot}] <= who_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_hand) begin
      rdata_q <= wait_mem[{res_q, head_cur}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      pend_status_q <= pend_status_d;
      pend_valid_q  <= pend_valid_d;
      pend_handed_q <= do_hand;
    end
  end

  // result register
  always_comb begin
    out_d.status         = pend_status_q;
    out_d.grant_valid    = pend_valid_q;
    out_d.grant_to       = '0;
    out_d.grant_resource = 1'b0;
    if (pend_valid_q) begin
      out_d.grant_to       = pend_handed_q ? rdata_q : who_q;
      out_d.grant_resource = res_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  ap_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending transfer");

  ap_hand_grants: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && pend_handed_q) |-> pend_valid_q)
    else $error("handover without grant");

  ap_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_i.capture, cmd_i.exec, cmd_i.load}) <= 1)
    else $error("overlapping controller commands");

  for (genvar r = 0; r < NUM_RESOURCES; r++) begin : g_chk
    ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q[r] <= QD_C)
      else $error("wait queue overflow");

    ap_waiters_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (count_q[r] != '0) |-> held_q[r])
      else $error("waiters on a free resource");
  end

endmodule
